FILE: sv/tcw_pkg.sv
package tcw_pkg;

  // default geometry
  localparam int DEF_COLUMNS    = 80;
  localparam int DEF_ROWS       = 25;
  localparam int DEF_TAB_SPACES = 4;

  // field widths
  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int TCOL_W   = 7;
  localparam int TROW_W   = 5;
  localparam int CADDR_W  = 11;
  localparam int CPOS_W   = 11;
  localparam int CELL_W   = 16;
  localparam int COLOR_W  = 4;

  // stream packing, first field in the lowest bits
  localparam int OPCODE_LSB = 0;
  localparam int CHAR_LSB   = OPCODE_LSB + OPCODE_W;
  localparam int TCOL_LSB   = CHAR_LSB + CHAR_W;
  localparam int TROW_LSB   = TCOL_LSB + TCOL_W;
  localparam int CADDR_LSB  = TROW_LSB + TROW_W;
  localparam int IN_BITS    = CADDR_LSB + CADDR_W;
  localparam int IN_W       = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS   = CPOS_W + CELL_W;
  localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;

  // register port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [0:0] {
    REG_FG_COLOR = 1'b0,
    REG_BG_COLOR = 1'b1
  } reg_idx_t;

  localparam logic [COLOR_W-1:0] RESET_FG = 4'd7;
  localparam logic [COLOR_W-1:0] RESET_BG = 4'd0;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [CELL_W-1:0] BLANK_RESET = {RESET_BG, RESET_FG, CH_SPACE};

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUT        = 2'd0,
    OP_SET_CURSOR = 2'd1,
    OP_CLEAR      = 2'd2,
    OP_READ       = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_PUT,
    ST_SCROLL_COPY,
    ST_SCROLL_FILL,
    ST_CLEAR,
    ST_READ,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] fg;
  } cfg_t;

endpackage

FILE: sv/tcw_ram.sv
module tcw_ram import tcw_pkg::*; #(
  parameter int WIDTH = CELL_W,
  parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/tcw_seq.sv
module tcw_seq import tcw_pkg::*; #(
  parameter int COLUMNS    = DEF_COLUMNS,
  parameter int ROWS       = DEF_ROWS,
  parameter int TAB_SPACES = DEF_TAB_SPACES,
  localparam int CELLS     = COLUMNS * ROWS,
  localparam int ADDR_W    = $clog2(CELLS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  output logic              mem_we,
  output logic [ADDR_W-1:0] mem_waddr,
  output logic [CELL_W-1:0] mem_wdata,
  output logic [ADDR_W-1:0] mem_raddr,
  input  logic [CELL_W-1:0] mem_rdata
);

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int REM_W = $clog2(TAB_SPACES + 1);

  st_t                st_r, st_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [ADDR_W-1:0]  copy_cnt_r, copy_cnt_nxt;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [CHAR_W-1:0]  char_r, char_nxt;
  logic [CELL_W-1:0]  data_r, data_nxt;
  logic               out_tvalid_r, out_tvalid_nxt;
  logic [CPOS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [CELL_W-1:0]  out_data_r, out_data_nxt;

  op_t                in_op;
  logic [CHAR_W-1:0]  in_char;
  logic [TCOL_W-1:0]  in_tcol;
  logic [TROW_W-1:0]  in_trow;
  logic [CADDR_W-1:0] in_caddr;

  logic               acc;
  logic               in_range;
  logic               wrap;
  logic               row_last;
  logic               put_scroll;
  logic               cnt_last;
  logic               copy_last;
  logic [REM_W-1:0]   rem_dec;
  logic               out_free;
  logic               item_end;
  logic               load;
  logic [ADDR_W-1:0]  cur_idx;
  logic [31:0]        pos_full;
  logic [CELL_W-1:0]  blank;
  logic [COL_W-1:0]   sat_col;
  logic [ROW_W-1:0]   sat_row;

  assign in_op    = op_t'(in_tdata[OPCODE_LSB +: OPCODE_W]);
  assign in_char  = in_tdata[CHAR_LSB +: CHAR_W];
  assign in_tcol  = in_tdata[TCOL_LSB +: TCOL_W];
  assign in_trow  = in_tdata[TROW_LSB +: TROW_W];
  assign in_caddr = in_tdata[CADDR_LSB +: CADDR_W];

  assign in_tready  = (st_r == ST_IDLE);
  assign acc        = in_tvalid && in_tready;
  assign in_range   = int'(in_caddr) < CELLS;
  assign wrap       = (col_r == COL_W'(COLUMNS - 1));
  assign row_last   = (row_r == ROW_W'(ROWS - 1));
  assign put_scroll = wrap && row_last;
  assign cnt_last   = (copy_cnt_r == ADDR_W'(CELLS - 1));
  assign copy_last  = (copy_cnt_r == ADDR_W'(CELLS - COLUMNS));
  assign rem_dec    = rem_r - REM_W'(1);
  assign out_free   = !out_tvalid_r || out_tready;
  assign cur_idx    = ADDR_W'(int'(row_r) * COLUMNS + int'(col_r));
  assign blank      = {cfg.bg, cfg.fg, CH_SPACE};
  assign sat_col    = (int'(in_tcol) < COLUMNS) ? COL_W'(in_tcol) : COL_W'(COLUMNS - 1);
  assign sat_row    = (int'(in_trow) < ROWS) ? ROW_W'(in_trow) : ROW_W'(ROWS - 1);

  // item finishes this cycle
  always_comb begin
    item_end = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (acc) begin
          unique case (in_op)
            OP_PUT:        item_end = (in_char == CH_CR) || (in_char == CH_BS) ||
                                      (in_char == CH_NUL) ||
                                      ((in_char == CH_LF) && !row_last);
            OP_SET_CURSOR: item_end = 1'b1;
            OP_CLEAR:      item_end = 1'b0;
            OP_READ:       item_end = !in_range;
            default:       item_end = 1'b0;
          endcase
        end
      end
      ST_PUT:         item_end = !put_scroll && (rem_dec == '0);
      ST_SCROLL_FILL: item_end = cnt_last && (rem_r == '0);
      ST_CLEAR:       item_end = cnt_last;
      ST_READ:        item_end = 1'b1;
      ST_DONE:        item_end = 1'b1;
      default:        item_end = 1'b0;
    endcase
  end

  assign load = item_end && out_free;

  // next state
  always_comb begin
    st_nxt = st_r;
    if (item_end) begin
      st_nxt = out_free ? ST_IDLE : ST_DONE;
    end else begin
      unique case (st_r)
        ST_INIT: begin
          if (cnt_last) st_nxt = ST_IDLE;
        end
        ST_IDLE: begin
          if (acc) begin
            unique case (in_op)
              OP_PUT:   st_nxt = (in_char == CH_LF) ? ST_SCROLL_COPY : ST_PUT;
              OP_CLEAR: st_nxt = ST_CLEAR;
              OP_READ:  st_nxt = ST_READ;
              default:  st_nxt = ST_IDLE;
            endcase
          end
        end
        ST_PUT:         st_nxt = put_scroll ? ST_SCROLL_COPY : ST_PUT;
        ST_SCROLL_COPY: begin
          if (copy_last) st_nxt = ST_SCROLL_FILL;
        end
        ST_SCROLL_FILL: begin
          if (cnt_last) st_nxt = ST_PUT;
        end
        default:        st_nxt = st_r;
      endcase
    end
  end

  // datapath and outputs
  always_comb begin
    col_nxt        = col_r;
    row_nxt        = row_r;
    copy_cnt_nxt   = copy_cnt_r;
    rem_nxt        = rem_r;
    char_nxt       = char_r;
    data_nxt       = data_r;
    mem_we         = 1'b0;
    mem_waddr      = cur_idx;
    mem_wdata      = blank;
    mem_raddr      = ADDR_W'(in_caddr);
    unique case (st_r)
      ST_INIT: begin
        mem_we       = 1'b1;
        mem_waddr    = copy_cnt_r;
        mem_wdata    = BLANK_RESET;
        copy_cnt_nxt = cnt_last ? '0 : copy_cnt_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (acc) begin
          data_nxt = '0;
          unique case (in_op)
            OP_PUT: begin
              unique case (in_char)
                CH_CR:  col_nxt = '0;
                CH_LF: begin
                  if (!row_last) row_nxt = row_r + ROW_W'(1);
                  rem_nxt = '0;
                end
                CH_TAB: begin
                  char_nxt = CH_SPACE;
                  rem_nxt  = REM_W'(TAB_SPACES);
                end
                CH_BS: begin
                  if (col_r == '0) begin
                    if (row_r != '0) row_nxt = row_r - ROW_W'(1);
                  end else begin
                    col_nxt = col_r - COL_W'(1);
                  end
                end
                CH_NUL: begin
                  col_nxt = col_r;
                end
                default: begin
                  char_nxt = in_char;
                  rem_nxt  = REM_W'(1);
                end
              endcase
            end
            OP_SET_CURSOR: begin
              col_nxt = sat_col;
              row_nxt = sat_row;
            end
            default: begin
              col_nxt = col_r;
            end
          endcase
        end
      end
      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = cur_idx;
        mem_wdata = {cfg.bg, cfg.fg, char_r};
        rem_nxt   = rem_dec;
        if (wrap) begin
          col_nxt = '0;
          // on the bottom row the cursor stays there after the scroll
          if (!row_last) row_nxt = row_r + ROW_W'(1);
        end else begin
          col_nxt = col_r + COL_W'(1);
        end
      end
      ST_SCROLL_COPY: begin
        // read one row ahead, write it back in the next cycle
        mem_raddr    = ADDR_W'(int'(copy_cnt_r) + COLUMNS);
        mem_we       = (copy_cnt_r != '0);
        mem_waddr    = copy_cnt_r - ADDR_W'(1);
        mem_wdata    = mem_rdata;
        copy_cnt_nxt = copy_last ? copy_cnt_r : copy_cnt_r + ADDR_W'(1);
      end
      ST_SCROLL_FILL: begin
        mem_we       = 1'b1;
        mem_waddr    = copy_cnt_r;
        copy_cnt_nxt = cnt_last ? '0 : copy_cnt_r + ADDR_W'(1);
      end
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = copy_cnt_r;
        copy_cnt_nxt = cnt_last ? '0 : copy_cnt_r + ADDR_W'(1);
        if (cnt_last) begin
          col_nxt = '0;
          row_nxt = '0;
        end
      end
      ST_READ: begin
        data_nxt = mem_rdata;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase

    pos_full       = 32'(int'(row_nxt) * COLUMNS + int'(col_nxt));
    out_pos_nxt    = load ? pos_full[CPOS_W-1:0] : out_pos_r;
    out_data_nxt   = load ? data_nxt : out_data_r;
    out_tvalid_nxt = load ? 1'b1 : (out_tready ? 1'b0 : out_tvalid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_INIT;
      col_r        <= '0;
      row_r        <= '0;
      copy_cnt_r   <= '0;
      rem_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      col_r        <= col_nxt;
      row_r        <= row_nxt;
      copy_cnt_r   <= copy_cnt_nxt;
      rem_r        <= rem_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    char_r     <= char_nxt;
    data_r     <= data_nxt;
    out_pos_r  <= out_pos_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'({out_data_r, out_pos_r});

  // cursor never leaves the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(col_r) < COLUMNS) && (int'(row_r) < ROWS))
    else $error("cursor out of range");

  // a waiting result holds still until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |=> (out_tvalid_r && $stable(out_tdata)))
    else $error("result changed while waiting");

  // sweep counter is back at zero between items
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_IDLE) |-> (copy_cnt_r == '0))
    else $error("sweep counter not cleared");

  // scroll writes land one row above the cell read the cycle before
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCROLL_COPY && copy_cnt_r != '0) |->
      (mem_waddr == ADDR_W'(int'($past(mem_raddr)) - COLUMNS)))
    else $error("scroll copy address mismatch");

endmodule

FILE: sv/text_console_writer_unit.sv
// text console: put character, set cursor, clear screen and read cell, one result per item
// items: set cursor, cr, bs, nul, out-of-range read and lf above the last row end when taken;
// printable and read end in ST_PUT or ST_READ; tab writes TAB_SPACES spaces; a scroll adds
// a copy and a last-row fill pass; a clear sweeps all cells; next taken while the result waits
// reset: synchronous active low; cursor to 0, colors to 7 on 0, then a clearing pass writes
// blank 0x0720 to every cell while in_tready stays low
module text_console_writer_unit import tcw_pkg::*; #(
  parameter int COLUMNS    = DEF_COLUMNS,
  parameter int ROWS       = DEF_ROWS,
  parameter int TAB_SPACES = DEF_TAB_SPACES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input item stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // opcode[1:0], char_code[9:2], target_col[16:10], target_row[21:17], cell_address[32:22]
  input  logic [IN_W-1:0]       in_tdata,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // cursor_pos[10:0], cell_data[26:11]
  output logic [OUT_W-1:0]      out_tdata,
  // register port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  // color registers
  logic [COLOR_W-1:0] fg_r, fg_nxt;
  logic [COLOR_W-1:0] bg_r, bg_nxt;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  cfg_t               cfg;

  // screen store port
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0]  mem_raddr;
  logic [CELL_W-1:0]  mem_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  // registers sit at byte addresses 0 and 4
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    fg_nxt = fg_r;
    bg_nxt = bg_r;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FG_COLOR: fg_nxt = cfg_pwdata[COLOR_W-1:0];
        REG_BG_COLOR: bg_nxt = cfg_pwdata[COLOR_W-1:0];
        default:      fg_nxt = fg_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FG_COLOR: cfg_prdata = CFG_DATA_W'(fg_r);
      REG_BG_COLOR: cfg_prdata = CFG_DATA_W'(bg_r);
      default:      cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= RESET_FG;
      bg_r <= RESET_BG;
    end else begin
      fg_r <= fg_nxt;
      bg_r <= bg_nxt;
    end
  end

  assign cfg.fg = fg_r;
  assign cfg.bg = bg_r;

  // sequencer: cursor logic, store sweeps and the result register
  tcw_seq #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .TAB_SPACES (TAB_SPACES)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // screen store, one write and one registered read per cycle
  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
